FILE: rtl/rgb_led_blink_pattern_sequencer_defines.svh
// Assertion macros for the RGB LED blink pattern sequencer.
// Depends on nothing; the asserting file supplies clk and rst_n in its scope.
`ifndef RGB_LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define RGB_LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBSEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rgbseq_pkg.sv
// Shared types and constants for the RGB LED blink pattern sequencer.
// Depends on nothing.
package rgbseq_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 4;
    localparam int MS_W    = 16;
    localparam int LEVEL_W = 8;
    localparam int LEN_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_START   = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED    = 3'd0,
        CFG_GREEN  = 3'd1,
        CFG_BLUE   = 3'd2,
        CFG_LENGTH = 3'd3,
        CFG_LOOP   = 3'd4
    } cfg_idx_t;

endpackage

FILE: rtl/rgbseq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rgbseq_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rgb_led_blink_pattern_sequencer.sv
// Top level of the RGB LED blink pattern sequencer.
// Depends on rgbseq_pkg, rgbseq_ram and rgb_led_blink_pattern_sequencer_defines.svh.
//
// The sequencer plays a blink pattern of on/off durations held in a table
// RAM (one word per entry: on time in the upper half, off time in the lower).
// Every input word is a tick of one ms, a table write, a start, an enable or
// a disable, and each one produces exactly one result word that shows the
// LED state after it. The block takes one input word per clock cycle unless
// the read-back stage and result register are full and the result is not
// taken. The sequencing state lives in flip-flops and is updated in the cycle
// the word is accepted; in that same cycle the table RAM is read at the entry
// the sequencer now points to. The next cycle uses the read data to form the
// remaining time of the current phase, and the word then moves into the result
// register. The durations of the current entry, which a tick needs, come from
// the read launched for the previous word, via the RAM output or a held copy;
// a write to the entry being read is bypassed around the RAM. The table has no
// reset: an entry must be written before the pattern plays it. Configuration
// registers (levels, pattern length, loop mode) are always ready and should
// only be written while no word is in flight.
module rgb_led_blink_pattern_sequencer #(
    parameter int MAX_ENTRIES = rgbseq_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbseq_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [rgbseq_pkg::OP_W-1:0]         op,
    input  logic [rgbseq_pkg::IDX_W-1:0]        entry_index,
    input  logic [rgbseq_pkg::MS_W-1:0]         on_ms,
    input  logic [rgbseq_pkg::MS_W-1:0]         off_ms,

    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [rgbseq_pkg::LEVEL_W-1:0]      red_out,
    output logic [rgbseq_pkg::LEVEL_W-1:0]      green_out,
    output logic [rgbseq_pkg::LEVEL_W-1:0]      blue_out,
    output logic                                led_lit,
    output logic                                pattern_done,
    output logic [rgbseq_pkg::MS_W-1:0]         ms_remaining
);

    import rgbseq_pkg::*;

    `include "rgb_led_blink_pattern_sequencer_defines.svh"

    // Entry address width, and a compare width that holds both the pattern
    // length register and the entry count itself.
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int IW    = (CW > IDX_W) ? CW : IDX_W;
    localparam int TBL_W = 2 * MS_W;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [IW-1:0] MAX_I = IW'(MAX_ENTRIES);
    localparam logic [MS_W-1:0] MS_SAT = '1;

    // Configuration registers.
    logic [LEVEL_W-1:0] red_cfg_reg;
    logic [LEVEL_W-1:0] green_cfg_reg;
    logic [LEVEL_W-1:0] blue_cfg_reg;
    logic [LEN_W-1:0]   length_cfg_reg;
    logic               loop_cfg_reg;

    // Sequencing state.
    logic [AW-1:0]   entry_reg,   entry_next;
    logic            lit_reg,     lit_next;
    logic [MS_W-1:0] elapsed_reg, elapsed_next;
    logic            done_reg,    done_next;
    logic            enabled_reg, enabled_next;

    // Read-back stage and the durations of the current entry.
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_bypass_reg, rd_bypass_next;
    logic [TBL_W-1:0] rd_wbuf_reg;
    logic [TBL_W-1:0] cur_hold_reg;

    // Result register.
    logic               res_valid_reg;
    logic [LEVEL_W-1:0] red_out_reg;
    logic [LEVEL_W-1:0] green_out_reg;
    logic [LEVEL_W-1:0] blue_out_reg;
    logic               lit_out_reg;
    logic               done_out_reg;
    logic [MS_W-1:0]    rem_out_reg;

    logic             accept;
    logic             rd_advance;
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [TBL_W-1:0] tbl_wdata;
    logic [TBL_W-1:0] ram_rdata;
    logic [TBL_W-1:0] fwd_dur;
    logic [TBL_W-1:0] cur_dur;
    logic [CW-1:0]    used_len;
    logic             entry_in_use;
    logic [MS_W-1:0]  tick_dur;
    logic [MS_W-1:0]  elapsed_inc;
    logic [MS_W-1:0]  res_dur;
    logic [MS_W-1:0]  res_rem;

    // ------------------------------------------------------------------
    // Configuration port. Writes never stall; unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cfg_reg    <= '0;
            green_cfg_reg  <= '0;
            blue_cfg_reg   <= '0;
            length_cfg_reg <= '0;
            loop_cfg_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RED:    red_cfg_reg    <= cfg_data;
                CFG_GREEN:  green_cfg_reg  <= cfg_data;
                CFG_BLUE:   blue_cfg_reg   <= cfg_data;
                CFG_LENGTH: length_cfg_reg <= cfg_data[LEN_W-1:0];
                CFG_LOOP:   loop_cfg_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // A length above the table size behaves as the table size. An entry at
    // or beyond the used length counts as having zero durations.
    assign used_len     = (CW'(length_cfg_reg) > MAX_C) ? MAX_C : CW'(length_cfg_reg);
    assign entry_in_use = CW'(entry_reg) < used_len;

    // ------------------------------------------------------------------
    // Handshake. The read-back stage drains into the result register
    // whenever that register is empty or being emptied.
    // ------------------------------------------------------------------
    assign rd_advance = rd_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !rd_valid_reg || rd_advance;
    assign accept     = item_valid && item_ready;

    // Table data of the current entry. The read launched by the previous
    // word is on the RAM output while that word is in the read-back stage;
    // otherwise the copy captured then is used.
    assign fwd_dur = rd_bypass_reg ? rd_wbuf_reg : ram_rdata;
    assign cur_dur = rd_valid_reg ? fwd_dur : cur_hold_reg;

    assign tick_dur    = !entry_in_use ? '0
                       : (lit_reg ? cur_dur[TBL_W-1:MS_W] : cur_dur[MS_W-1:0]);
    assign elapsed_inc = (elapsed_reg == MS_SAT) ? elapsed_reg : elapsed_reg + MS_W'(1);

    assign tbl_waddr = AW'(entry_index);
    assign tbl_wdata = {on_ms, off_ms};

    // ------------------------------------------------------------------
    // Sequencing update, done in the cycle a word is accepted.
    // ------------------------------------------------------------------
    always_comb
    begin
        entry_next   = entry_reg;
        lit_next     = lit_reg;
        elapsed_next = elapsed_reg;
        done_next    = done_reg;
        enabled_next = enabled_reg;
        tbl_we       = 1'b0;

        if (accept)
        begin
            unique case (op_t'(op))
                OP_TICK:
                begin
                    // Nothing moves while finished or disabled.
                    if (!done_reg && enabled_reg)
                    begin
                        if (elapsed_inc < tick_dur)
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        else
                        begin
                            elapsed_next = '0;
                            if (lit_reg)
                            begin
                                lit_next = 1'b0;
                            end
                            else if (CW'(entry_reg) + CW'(1) >= used_len)
                            begin
                                if (loop_cfg_reg)
                                begin
                                    entry_next = '0;
                                    lit_next   = 1'b1;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                entry_next = entry_reg + AW'(1);
                                lit_next   = 1'b1;
                            end
                        end
                    end
                end
                OP_WRITE:
                begin
                    tbl_we = IW'(entry_index) < MAX_I;
                end
                OP_START:
                begin
                    entry_next   = '0;
                    elapsed_next = '0;
                    if (used_len == '0)
                    begin
                        done_next = 1'b1;
                        lit_next  = 1'b0;
                    end
                    else
                    begin
                        done_next = 1'b0;
                        lit_next  = enabled_reg;
                    end
                end
                OP_ENABLE:
                begin
                    enabled_next = 1'b1;
                end
                OP_DISABLE:
                begin
                    enabled_next = 1'b0;
                    if (lit_reg)
                    begin
                        lit_next     = 1'b0;
                        elapsed_next = '0;
                    end
                end
                default:
                begin
                    // Unknown operations leave the state alone.
                end
            endcase
        end
    end

    // A write to the entry being read this cycle would return stale data,
    // so the write data is kept and used instead.
    assign rd_bypass_next = tbl_we && (tbl_waddr == entry_next);

    always_comb
    begin
        if (accept)
        begin
            rd_valid_next = 1'b1;
        end
        else if (rd_advance)
        begin
            rd_valid_next = 1'b0;
        end
        else
        begin
            rd_valid_next = rd_valid_reg;
        end
    end

    rgbseq_ram #(
        .WIDTH (TBL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (entry_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg     <= '0;
            lit_reg       <= 1'b0;
            elapsed_reg   <= '0;
            done_reg      <= 1'b1;
            enabled_reg   <= 1'b1;
            rd_valid_reg  <= 1'b0;
            rd_bypass_reg <= 1'b0;
        end
        else
        begin
            entry_reg    <= entry_next;
            lit_reg      <= lit_next;
            elapsed_reg  <= elapsed_next;
            done_reg     <= done_next;
            enabled_reg  <= enabled_next;
            rd_valid_reg <= rd_valid_next;
            if (accept)
            begin
                rd_bypass_reg <= rd_bypass_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_wbuf_reg <= tbl_wdata;
        end
        if (rd_valid_reg)
        begin
            cur_hold_reg <= fwd_dur;
        end
    end

    // ------------------------------------------------------------------
    // Read-back stage: the state registers already hold the state after
    // the word, and the RAM output holds the durations of its entry.
    // ------------------------------------------------------------------
    assign res_dur = !entry_in_use ? '0
                   : (lit_reg ? fwd_dur[TBL_W-1:MS_W] : fwd_dur[MS_W-1:0]);
    assign res_rem = (!done_reg && enabled_reg && (res_dur > elapsed_reg))
                   ? res_dur - elapsed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rd_advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_advance)
        begin
            red_out_reg   <= lit_reg ? red_cfg_reg   : '0;
            green_out_reg <= lit_reg ? green_cfg_reg : '0;
            blue_out_reg  <= lit_reg ? blue_cfg_reg  : '0;
            lit_out_reg   <= lit_reg;
            done_out_reg  <= done_reg;
            rem_out_reg   <= res_rem;
        end
    end

    assign result_valid = res_valid_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign led_lit      = lit_out_reg;
    assign pattern_done = done_out_reg;
    assign ms_remaining = rem_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RGBSEQ_ASSERT_NOW(a_done_is_dark, done_reg, !lit_reg, "lit after pattern finished")
    `RGBSEQ_ASSERT_NOW(a_disabled_is_dark, !enabled_reg, !lit_reg, "lit while disabled")
    `RGBSEQ_ASSERT_NOW(a_stall_only_when_full, !item_ready, rd_valid_reg && res_valid_reg && !result_ready, "input stalled without a full pipeline")
    `RGBSEQ_ASSERT_NOW(a_lit_starts_fresh, $rose(lit_reg), elapsed_reg == '0, "lit phase began with time elapsed")
    `RGBSEQ_ASSERT_NEXT(a_read_lands, accept, rd_valid_reg, "accepted word missing from read-back stage")

endmodule

FILE: verif/rgbseq_led_view_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB LED blink pattern sequencer: follows the register, input and result
// channels, predicts the LED view after every input word and compares it field by field.
// Depends on rgbseq_pkg.
module rgbseq_led_view_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rgbseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbseq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                item_valid,
    input  logic                                item_ready,
    input  logic [rgbseq_pkg::OP_W-1:0]         op,
    input  logic [rgbseq_pkg::IDX_W-1:0]        entry_index,
    input  logic [rgbseq_pkg::MS_W-1:0]         on_ms,
    input  logic [rgbseq_pkg::MS_W-1:0]         off_ms,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [rgbseq_pkg::LEVEL_W-1:0]      red_out,
    input  logic [rgbseq_pkg::LEVEL_W-1:0]      green_out,
    input  logic [rgbseq_pkg::LEVEL_W-1:0]      blue_out,
    input  logic                                led_lit,
    input  logic                                pattern_done,
    input  logic [rgbseq_pkg::MS_W-1:0]         ms_remaining,
    output int                                  mismatches,
    output int                                  words_pending,
    output int                                  words_checked
);
    import rgbseq_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic               lit;
        logic               done;
        logic [MS_W-1:0]    remaining;
    } led_view_t;

    // Predicted sequencer state and register copies.
    logic [MS_W-1:0]    on_table [TABLE_DEPTH];
    logic [MS_W-1:0]    off_table [TABLE_DEPTH];
    int unsigned        cur_entry;
    logic               phase_on;
    logic               finished;
    logic               running;
    logic [MS_W-1:0]    elapsed;
    logic [LEVEL_W-1:0] red_lvl;
    logic [LEVEL_W-1:0] green_lvl;
    logic [LEVEL_W-1:0] blue_lvl;
    logic [LEN_W-1:0]   length_cfg;
    logic               loop_cfg;

    led_view_t views_due[$];

    function automatic void clear_sequencer();
        cur_entry  = 0;
        phase_on   = 1'b0;
        elapsed    = '0;
        finished   = 1'b1;
        running    = 1'b1;
        red_lvl    = '0;
        green_lvl  = '0;
        blue_lvl   = '0;
        length_cfg = '0;
        loop_cfg   = 1'b0;
    endfunction

    function automatic int unsigned entries_in_use();
        return (32'(length_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(length_cfg);
    endfunction

    // An entry beyond the length in use counts as zero duration.
    function automatic int unsigned phase_ms();
        if (cur_entry >= entries_in_use())
            return 0;
        return phase_on ? 32'(on_table[cur_entry]) : 32'(off_table[cur_entry]);
    endfunction

    function automatic void advance_one_ms();
        if (finished || !running)
            return;
        if (elapsed != '1)
            elapsed++;
        if (32'(elapsed) < phase_ms())
            return;
        elapsed = '0;
        if (phase_on) begin
            phase_on = 1'b0;
            return;
        end
        if (cur_entry + 1 >= entries_in_use()) begin
            if (loop_cfg) begin
                cur_entry = 0;
                phase_on  = 1'b1;
            end
            else begin
                finished = 1'b1;
            end
        end
        else begin
            cur_entry++;
            phase_on = 1'b1;
        end
    endfunction

    function automatic void apply_word(logic [OP_W-1:0] word_op, logic [IDX_W-1:0] word_idx,
                                       logic [MS_W-1:0] word_on, logic [MS_W-1:0] word_off);
        case (word_op)
            OP_TICK:
                advance_one_ms();
            OP_WRITE:
            begin
                on_table[word_idx]  = word_on;
                off_table[word_idx] = word_off;
            end
            OP_START:
            begin
                cur_entry = 0;
                elapsed   = '0;
                if (entries_in_use() == 0) begin
                    finished = 1'b1;
                    phase_on = 1'b0;
                end
                else begin
                    finished = 1'b0;
                    phase_on = running;
                end
            end
            OP_ENABLE:
                running = 1'b1;
            OP_DISABLE:
            begin
                running = 1'b0;
                if (phase_on) begin
                    phase_on = 1'b0;
                    elapsed  = '0;
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic void store_setting(logic [CFG_IDX_W-1:0] reg_idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (reg_idx)
            CFG_RED:    red_lvl    = value;
            CFG_GREEN:  green_lvl  = value;
            CFG_BLUE:   blue_lvl   = value;
            CFG_LENGTH: length_cfg = value[LEN_W-1:0];
            CFG_LOOP:   loop_cfg   = value[0];
            default:    ;
        endcase
    endfunction

    function automatic led_view_t current_view();
        led_view_t   view;
        int unsigned due_ms;
        view.red       = phase_on ? red_lvl : '0;
        view.green     = phase_on ? green_lvl : '0;
        view.blue      = phase_on ? blue_lvl : '0;
        view.lit       = phase_on;
        view.done      = finished;
        view.remaining = '0;
        if (!finished && running) begin
            due_ms = phase_ms();
            if (due_ms > 32'(elapsed))
                view.remaining = MS_W'(due_ms - 32'(elapsed));
        end
        return view;
    endfunction

    function automatic void check_field(string field, logic [MS_W-1:0] want,
                                        logic [MS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // A result is matched before the word accepted at the same edge is predicted.
    always @(posedge clk or negedge rst_n) begin
        led_view_t want;
        if (!rst_n) begin
            clear_sequencer();
            views_due.delete();
            mismatches    = 0;
            words_checked = 0;
            words_pending <= 0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (views_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    mismatches++;
                end
                else begin
                    want = views_due.pop_front();
                    check_field("red_out", MS_W'(want.red), MS_W'(red_out));
                    check_field("green_out", MS_W'(want.green), MS_W'(green_out));
                    check_field("blue_out", MS_W'(want.blue), MS_W'(blue_out));
                    check_field("led_lit", MS_W'(want.lit), MS_W'(led_lit));
                    check_field("pattern_done", MS_W'(want.done), MS_W'(pattern_done));
                    check_field("ms_remaining", want.remaining, ms_remaining);
                    words_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                store_setting(cfg_index, cfg_data);
            if (item_valid && item_ready) begin
                apply_word(op, entry_index, on_ms, off_ms);
                views_due.push_back(current_view());
            end
            words_pending <= views_due.size();
        end
    end

endmodule

FILE: verif/tb_rgb_led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps
// Testbench top for the RGB LED blink pattern sequencer: drives registers and input words,
// paces the result side and gives the verdict. Depends on rgbseq_pkg, the sequencer RTL
// and rgbseq_led_view_checker, which does all prediction and comparison.
module tb_rgb_led_blink_pattern_sequencer;
    import rgbseq_pkg::*;

    // Opcodes and a register index that the block must ignore.
    localparam logic [OP_W-1:0]      OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

    localparam int MAX_GAP         = 18;
    localparam int BACKLOG_CYCLES  = 300;
    // Idle cycles added after the last result is taken, as margin.
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_ROUNDS   = 10;
    localparam int WORDS_PER_ROUND = 40;
    localparam int LONG_PHASE_MS   = 40;
    // The slowest legal run is well under a million ns; this allows several times that.
    localparam int RUN_LIMIT_NS    = 5_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   item_valid;
    logic                   item_ready;
    logic [OP_W-1:0]        op;
    logic [IDX_W-1:0]       entry_index;
    logic [MS_W-1:0]        on_ms;
    logic [MS_W-1:0]        off_ms;
    logic                   result_valid;
    logic                   result_ready;
    logic [LEVEL_W-1:0]     red_out;
    logic [LEVEL_W-1:0]     green_out;
    logic [LEVEL_W-1:0]     blue_out;
    logic                   led_lit;
    logic                   pattern_done;
    logic [MS_W-1:0]        ms_remaining;

    int mismatches;
    int words_pending;
    int words_checked;

    // Pacing controls shared between the word driver and the result side.
    bit sender_gaps;
    bit receiver_gaps;
    bit backlog_req;

    int words_by_op [8];
    int cfg_writes;
    int settings_applied;

    rgb_led_blink_pattern_sequencer dut (.*);

    rgbseq_led_view_checker led_view_check (.*);

    always #5 clk = ~clk;

    // Offer one input word after an optional random gap, then hold it until accepted.
    // Valid is left high so back-to-back words need no extra cycle.
    task automatic send_word(input logic [OP_W-1:0] w_op, input logic [IDX_W-1:0] w_idx,
                             input logic [MS_W-1:0] w_on, input logic [MS_W-1:0] w_off);
        int gap;
        gap = sender_gaps ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= w_op;
        entry_index <= w_idx;
        on_ms       <= w_on;
        off_ms      <= w_off;
        do @(posedge clk); while (!item_ready);
        words_by_op[w_op]++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
    endtask

    // Registers are only touched with nothing in flight; callers drain first.
    task automatic configure(input logic [CFG_DATA_W-1:0] red, input logic [CFG_DATA_W-1:0] green,
                             input logic [CFG_DATA_W-1:0] blue,
                             input logic [CFG_DATA_W-1:0] length,
                             input logic [CFG_DATA_W-1:0] looping);
        write_register(CFG_RED, red);
        write_register(CFG_GREEN, green);
        write_register(CFG_BLUE, blue);
        write_register(CFG_LENGTH, length);
        write_register(CFG_LOOP, looping);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Stop offering words and wait until every predicted result word has been taken.
    // The first edge lets the pending count catch up with a word accepted just now.
    task automatic wait_until_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly short durations so patterns really advance; now and then zero, full scale,
    // or a random 16-bit value.
    function automatic logic [MS_W-1:0] pick_duration();
        int roll;
        roll = $urandom_range(31, 0);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return MS_W'($urandom());
        if (roll < 5)
            return '0;
        return MS_W'($urandom_range(5, 1));
    endfunction

    // Random traffic is dominated by ticks so the pattern keeps moving; the other
    // operations are sprinkled in, and unused opcodes show up rarely as noise.
    task automatic send_random_word();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 64)
            send_word(OP_TICK, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));
        else if (pick < 78)
            send_word(OP_WRITE, IDX_W'($urandom()), pick_duration(), pick_duration());
        else if (pick < 84)
            send_word(OP_START, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));
        else if (pick < 91)
            send_word(OP_ENABLE, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));
        else if (pick < 96)
            send_word(OP_DISABLE, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));
        else
            send_word(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), IDX_W'($urandom()),
                      MS_W'($urandom()), MS_W'($urandom()));
    endtask

    // Result side. Before each word it draws a stall, unless gaps are switched off.
    // When a backlog is requested it holds ready low for a long stretch so the block
    // fills up and has to push back on the input channel.
    initial begin
        int hold;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (backlog_req) begin
                hold = BACKLOG_CYCLES;
                backlog_req = 1'b0;
            end
            else begin
                hold = receiver_gaps ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (hold > 0) begin
                result_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    // Main stimulus: directed opening, randomized rounds with fresh settings, and one
    // long lit phase at the end.
    initial begin
        int k;
        int round;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_RED;
        cfg_data         = '0;
        item_valid       = 1'b0;
        op               = OP_TICK;
        entry_index      = '0;
        on_ms            = '0;
        off_ms           = '0;
        sender_gaps      = 1'b1;
        receiver_gaps    = 1'b1;
        backlog_req      = 1'b0;
        cfg_writes       = 0;
        settings_applied = 0;
        foreach (words_by_op[i])
            words_by_op[i] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Every table entry is written before any start, so the block
        // never plays an entry that holds no data. Entry 0 has zero durations, entry 15
        // the full-scale ones.
        configure(8'hFF, 8'h00, 8'h5A, CFG_DATA_W'(MAX_ENTRIES_DEF), 8'h00);
        for (k = 0; k < MAX_ENTRIES_DEF; k++) begin
            if (k == 0)
                send_word(OP_WRITE, IDX_W'(k), 16'h0000, 16'h0000);
            else if (k == MAX_ENTRIES_DEF - 1)
                send_word(OP_WRITE, IDX_W'(k), 16'hFFFF, 16'hFFFF);
            else
                send_word(OP_WRITE, IDX_W'(k), MS_W'(k % 3 + 1), MS_W'(k % 2 + 1));
        end
        // Zero on time: lit, then dark one tick later, then entry 1 on the next tick.
        send_word(OP_START, 4'h0, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
        send_word(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        // Disable in the lit phase, a tick that must do nothing, and a restart while
        // disabled, which must stay dark.
        send_word(OP_DISABLE, 4'h0, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_word(OP_START, 4'h0, 16'h0000, 16'h0000);
        // Enable alone changes nothing visible; the due phase change comes with the tick.
        send_word(OP_ENABLE, 4'h0, 16'h0000, 16'h0000);
        send_word(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        // Unused opcodes, with payload bits high, must leave the state alone.
        send_word(OP_SPARE_LO, 4'hF, 16'hFFFF, 16'hFFFF);
        send_word(OP_SPARE_HI, 4'h5, 16'hA5A5, 16'h5A5A);
        send_word(OP_TICK, 4'h0, 16'h0000, 16'h0000);

        // Random rounds. Each one reprograms every register while the pattern may still
        // be playing, which also covers shortening the pattern under the current entry.
        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_until_idle();
            case (round)
                0: configure(8'hFF, 8'hFF, 8'hFF, CFG_DATA_W'(MAX_ENTRIES_DEF), 8'h01);
                1: configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                2: configure(8'h80, 8'h7F, 8'h01, 8'h1F, 8'hFF);
                3: configure(8'h3C, 8'hC3, 8'h99, 8'h01, 8'h00);
                default: configure(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                   CFG_DATA_W'($urandom()),
                                   CFG_DATA_W'($urandom_range(MAX_ENTRIES_DEF + 2, 0)),
                                   CFG_DATA_W'($urandom()));
            endcase
            // An unused register index must be harmless.
            if (round == 1) begin
                write_register(CFG_SPARE, 8'hFF);
                cfg_valid <= 1'b0;
            end
            sender_gaps   = $urandom_range(3, 0) != 0;
            receiver_gaps = $urandom_range(3, 0) != 0;
            // One round fills the block: the sender runs flat out against a long stall.
            if (round == 4) begin
                sender_gaps = 1'b0;
                backlog_req = 1'b1;
            end
            repeat (4)
                send_word(OP_WRITE, IDX_W'($urandom()), MS_W'($urandom_range(3, 0)),
                          MS_W'($urandom_range(3, 0)));
            send_word(OP_START, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));
            repeat (WORDS_PER_ROUND)
                send_random_word();
        end

        // One long lit phase with no gaps anywhere: the elapsed count climbs through the
        // whole on time, the LED goes dark, and the zero off time loops back to lit.
        wait_until_idle();
        configure(8'h01, 8'h80, 8'hFE, 8'h01, 8'h01);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_word(OP_WRITE, 4'h0, MS_W'(LONG_PHASE_MS), 16'h0000);
        send_word(OP_ENABLE, 4'h0, 16'h0000, 16'h0000);
        send_word(OP_START, 4'h0, 16'h0000, 16'h0000);
        repeat (LONG_PHASE_MS + 2)
            send_word(OP_TICK, IDX_W'($urandom()), MS_W'($urandom()), MS_W'($urandom()));

        wait_until_idle();

        $display("Sent %0d ticks, %0d table writes, %0d starts, %0d enables, %0d disables,",
                 words_by_op[OP_TICK], words_by_op[OP_WRITE], words_by_op[OP_START],
                 words_by_op[OP_ENABLE], words_by_op[OP_DISABLE]);
        $display("%0d unused ops; %0d register writes across %0d settings; %0d results checked",
                 words_by_op[5] + words_by_op[6] + words_by_op[7],
                 cfg_writes, settings_applied, words_checked);
        if (mismatches == 0)
            $display("rgb_led_blink_pattern_sequencer test passed");
        else
            $display("rgb_led_blink_pattern_sequencer test failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("rgb_led_blink_pattern_sequencer test failed");
        $finish;
    end

endmodule
